@@ design/aarm_pkg.sv @@
// Shared constants, types and arithmetic helpers for the axis-angle rotation matrix core.
// No dependencies; every other file in the design imports this package.
package aarm_pkg;

	localparam int TRIG_ITERATIONS = 30;
	localparam int ROOT_STEPS = 32;
	localparam int QUOT_BITS = 31;
	localparam int ZW = 40;
	localparam int XW = 34;

	localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;
	localparam logic signed [63:0] PI_Q32 = 64'sd13493037705;
	localparam logic signed [63:0] TWO_PI_Q32 = 64'sd26986075409;
	localparam logic signed [63:0] HALF_PI_Q32 = 64'sd6746518852;
	localparam logic signed [63:0] CORDIC_GAIN_Q30 = 64'sd652032874;

	localparam logic signed [ZW-1:0] ATAN_TAB [12] = '{
		40'sd3373259426, 40'sd1991351318, 40'sd1052175346, 40'sd534100635,
		40'sd268086748, 40'sd134174063, 40'sd67103403, 40'sd33553749,
		40'sd16777131, 40'sd8388597, 40'sd4194303, 40'sd2097152
	};

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic zero;
	} axis_t;

	typedef struct packed {
		logic signed [31:0] c;
		logic signed [31:0] s;
	} trig_t;

	function automatic logic signed [ZW-1:0] atan_step(input int i);
		if (i < 12)
			return ATAN_TAB[i];
		else if (i <= 32)
			return ZW'(64'sd1 <<< (32 - i));
		else
			return '0;
	endfunction

	function automatic logic signed [63:0] rnd30(input logic signed [63:0] p);
		return (p + 64'sd536870912) >>> 30;
	endfunction

	function automatic logic signed [31:0] clamp_q30(input logic signed [63:0] v);
		if (v > ONE_Q30)
			return 32'(ONE_Q30);
		else if (v < -ONE_Q30)
			return 32'(-ONE_Q30);
		else
			return 32'(v);
	endfunction

endpackage

@@ design/aarm_norm.sv @@
// Axis normalisation pipeline: pre-shift, sum of squares, square root and division.
// Depends on aarm_pkg; carries the angle alongside for the trigonometric stage.
module aarm_norm (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [31:0] angle,
	input  logic signed [31:0] axis_x,
	input  logic signed [31:0] axis_y,
	input  logic signed [31:0] axis_z,
	output logic out_valid,
	output aarm_pkg::axis_t unit_axis,
	output logic signed [31:0] angle_out
);
	import aarm_pkg::*;

	typedef struct packed {
		logic signed [31:0] ang;
		logic [2:0] neg;
		logic zero;
	} side_t;

	logic signed [31:0] vin [3];
	logic [31:0] mag_c [3];
	logic [4:0] k_c;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [31:0] mag_s1 [3];
	logic [31:0] mag_s2 [3];
	logic [31:0] sh_s3 [3];
	logic [31:0] sh_s4 [3];
	logic [63:0] sq_s4 [3];
	logic [31:0] or_s1;
	logic [4:0] k_s2;
	side_t sd_s1, sd_s2, sd_s3, sd_s4;

	logic rt_v_s [ROOT_STEPS+1];
	logic [63:0] rt_rem_s [ROOT_STEPS+1];
	logic [63:0] rt_res_s [ROOT_STEPS+1];
	logic [31:0] rt_sh_s [ROOT_STEPS+1][3];
	side_t rt_sd_s [ROOT_STEPS+1];

	logic dv_v_s [QUOT_BITS+1];
	logic [32:0] dv_rem_s [QUOT_BITS+1][3];
	logic [QUOT_BITS-1:0] dv_lo_s [QUOT_BITS+1][3];
	logic [QUOT_BITS-1:0] dv_q_s [QUOT_BITS+1][3];
	logic [31:0] dv_d_s [QUOT_BITS+1];
	side_t dv_sd_s [QUOT_BITS+1];

	logic [61:0] num_c [3];
	logic v_out_q;
	axis_t unit_q;
	logic signed [31:0] ang_q;

	assign vin[0] = axis_x;
	assign vin[1] = axis_y;
	assign vin[2] = axis_z;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			mag_c[j] = vin[j][31] ? (~vin[j] + 32'd1) : vin[j];
		end
	end

	always_comb begin
		k_c = '0;
		for (int i = 0; i < 30; i++) begin
			if (or_s1[i])
				k_c = 5'(30 - i);
		end
		if (or_s1[31] || or_s1[30])
			k_c = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				mag_s1[j] <= mag_c[j];
				mag_s2[j] <= mag_s1[j];
				sh_s3[j] <= mag_s2[j] << k_s2;
				sh_s4[j] <= sh_s3[j];
				sq_s4[j] <= 64'(sh_s3[j]) * 64'(sh_s3[j]);
			end
			or_s1 <= mag_c[0] | mag_c[1] | mag_c[2];
			sd_s1.ang <= angle;
			sd_s1.neg <= {axis_z[31], axis_y[31], axis_x[31]};
			sd_s1.zero <= 1'b0;
			k_s2 <= k_c;
			sd_s2 <= {sd_s1.ang, sd_s1.neg, (or_s1 == 32'd0)};
			sd_s3 <= sd_s2;
			sd_s4 <= sd_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rt_v_s[0] <= 1'b0;
		else if (en)
			rt_v_s[0] <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_rem_s[0] <= sq_s4[0] + sq_s4[1] + sq_s4[2];
			rt_res_s[0] <= '0;
			rt_sh_s[0] <= sh_s4;
			rt_sd_s[0] <= sd_s4;
		end
	end

	for (genvar n = 0; n < ROOT_STEPS; n++) begin : g_root
		logic [63:0] bit_c, trial_c, rem_c, res_c;

		always_comb begin
			bit_c = 64'd1 << (62 - 2 * n);
			trial_c = rt_res_s[n] + bit_c;
			if (rt_rem_s[n] >= trial_c) begin
				rem_c = rt_rem_s[n] - trial_c;
				res_c = (rt_res_s[n] >> 1) + bit_c;
			end else begin
				rem_c = rt_rem_s[n];
				res_c = rt_res_s[n] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				rt_v_s[n+1] <= 1'b0;
			else if (en)
				rt_v_s[n+1] <= rt_v_s[n];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_rem_s[n+1] <= rem_c;
				rt_res_s[n+1] <= res_c;
				rt_sh_s[n+1] <= rt_sh_s[n];
				rt_sd_s[n+1] <= rt_sd_s[n];
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			num_c[j] = {rt_sh_s[ROOT_STEPS][j], 30'd0}
				+ 62'(rt_res_s[ROOT_STEPS][31:1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_v_s[0] <= 1'b0;
		else if (en)
			dv_v_s[0] <= rt_v_s[ROOT_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				dv_rem_s[0][j] <= 33'(num_c[j][61:QUOT_BITS]);
				dv_lo_s[0][j] <= num_c[j][QUOT_BITS-1:0];
				dv_q_s[0][j] <= '0;
			end
			dv_d_s[0] <= rt_res_s[ROOT_STEPS][31:0];
			dv_sd_s[0] <= rt_sd_s[ROOT_STEPS];
		end
	end

	for (genvar n = 0; n < QUOT_BITS; n++) begin : g_div
		logic [32:0] try_c [3];
		logic [32:0] rem_c [3];
		logic qb_c [3];

		always_comb begin
			for (int j = 0; j < 3; j++) begin
				try_c[j] = {dv_rem_s[n][j][31:0], dv_lo_s[n][j][QUOT_BITS-1]};
				qb_c[j] = (try_c[j] >= {1'b0, dv_d_s[n]});
				rem_c[j] = qb_c[j] ? (try_c[j] - {1'b0, dv_d_s[n]}) : try_c[j];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v_s[n+1] <= 1'b0;
			else if (en)
				dv_v_s[n+1] <= dv_v_s[n];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 3; j++) begin
					dv_rem_s[n+1][j] <= rem_c[j];
					dv_lo_s[n+1][j] <= dv_lo_s[n][j] << 1;
					dv_q_s[n+1][j] <= {dv_q_s[n][j][QUOT_BITS-2:0], qb_c[j]};
				end
				dv_d_s[n+1] <= dv_d_s[n];
				dv_sd_s[n+1] <= dv_sd_s[n];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_out_q <= 1'b0;
		else if (en)
			v_out_q <= dv_v_s[QUOT_BITS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unit_q.x <= dv_sd_s[QUOT_BITS].neg[0] ? -{1'b0, dv_q_s[QUOT_BITS][0]}
				: {1'b0, dv_q_s[QUOT_BITS][0]};
			unit_q.y <= dv_sd_s[QUOT_BITS].neg[1] ? -{1'b0, dv_q_s[QUOT_BITS][1]}
				: {1'b0, dv_q_s[QUOT_BITS][1]};
			unit_q.z <= dv_sd_s[QUOT_BITS].neg[2] ? -{1'b0, dv_q_s[QUOT_BITS][2]}
				: {1'b0, dv_q_s[QUOT_BITS][2]};
			unit_q.zero <= dv_sd_s[QUOT_BITS].zero;
			ang_q <= dv_sd_s[QUOT_BITS].ang;
		end
	end

	assign out_valid = v_out_q;
	assign unit_axis = unit_q;
	assign angle_out = ang_q;

endmodule

@@ design/aarm_cordic.sv @@
// Angle reduction and pipelined CORDIC rotation giving cosine and sine in Q1.30.
// Depends on aarm_pkg; passes the unit axis through alongside.
module aarm_cordic (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [31:0] angle,
	input  aarm_pkg::axis_t unit_axis,
	output logic out_valid,
	output aarm_pkg::axis_t axis_out,
	output aarm_pkg::trig_t trig
);
	import aarm_pkg::*;

	logic signed [63:0] z0_c, z1_c;
	logic signed [63:0] z2_c;
	logic neg_c;

	logic v_s1, v_s2;
	logic signed [ZW-1:0] z_s1;
	axis_t ax_s1, ax_s2;

	logic cr_v_s [TRIG_ITERATIONS+1];
	logic signed [XW-1:0] cr_x_s [TRIG_ITERATIONS+1];
	logic signed [XW-1:0] cr_y_s [TRIG_ITERATIONS+1];
	logic signed [ZW-1:0] cr_z_s [TRIG_ITERATIONS+1];
	logic cr_neg_s [TRIG_ITERATIONS+1];
	axis_t cr_ax_s [TRIG_ITERATIONS+1];

	logic signed [63:0] cx_c, sy_c;
	logic v_out_q;
	axis_t ax_q;
	trig_t trig_q;

	always_comb begin
		z0_c = 64'(angle) <<< 4;
		if (z0_c > PI_Q32)
			z1_c = z0_c - TWO_PI_Q32;
		else if (z0_c < -PI_Q32)
			z1_c = z0_c + TWO_PI_Q32;
		else
			z1_c = z0_c;
	end

	always_comb begin
		z2_c = 64'(z_s1);
		neg_c = 1'b0;
		if (z2_c > HALF_PI_Q32) begin
			z2_c = z2_c - PI_Q32;
			neg_c = 1'b1;
		end else if (z2_c < -HALF_PI_Q32) begin
			z2_c = z2_c + PI_Q32;
			neg_c = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			cr_v_s[0] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			cr_v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1 <= ZW'(z1_c);
			ax_s1 <= unit_axis;
			cr_x_s[0] <= XW'(CORDIC_GAIN_Q30);
			cr_y_s[0] <= '0;
			cr_z_s[0] <= ZW'(z2_c);
			cr_neg_s[0] <= neg_c;
			cr_ax_s[0] <= ax_s1;
		end
	end

	for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_iter
		logic signed [XW-1:0] xn_c, yn_c;
		logic signed [ZW-1:0] zn_c;

		always_comb begin
			if (!cr_z_s[i][ZW-1]) begin
				xn_c = cr_x_s[i] - (cr_y_s[i] >>> i);
				yn_c = cr_y_s[i] + (cr_x_s[i] >>> i);
				zn_c = cr_z_s[i] - atan_step(i);
			end else begin
				xn_c = cr_x_s[i] + (cr_y_s[i] >>> i);
				yn_c = cr_y_s[i] - (cr_x_s[i] >>> i);
				zn_c = cr_z_s[i] + atan_step(i);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				cr_v_s[i+1] <= 1'b0;
			else if (en)
				cr_v_s[i+1] <= cr_v_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cr_x_s[i+1] <= xn_c;
				cr_y_s[i+1] <= yn_c;
				cr_z_s[i+1] <= zn_c;
				cr_neg_s[i+1] <= cr_neg_s[i];
				cr_ax_s[i+1] <= cr_ax_s[i];
			end
		end
	end

	always_comb begin
		cx_c = cr_neg_s[TRIG_ITERATIONS] ? -64'(cr_x_s[TRIG_ITERATIONS])
			: 64'(cr_x_s[TRIG_ITERATIONS]);
		sy_c = cr_neg_s[TRIG_ITERATIONS] ? -64'(cr_y_s[TRIG_ITERATIONS])
			: 64'(cr_y_s[TRIG_ITERATIONS]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_out_q <= 1'b0;
		else if (en)
			v_out_q <= cr_v_s[TRIG_ITERATIONS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			trig_q.c <= clamp_q30(cx_c);
			trig_q.s <= clamp_q30(sy_c);
			ax_q <= cr_ax_s[TRIG_ITERATIONS];
		end
	end

	assign v_s2 = v_out_q;
	assign ax_s2 = ax_q;
	assign out_valid = v_s2;
	assign axis_out = ax_s2;
	assign trig = trig_q;

endmodule

@@ design/aarm_matrix.sv @@
// Rodrigues matrix assembly: products, rounding, sums and saturation into Q1.30 entries.
// Depends on aarm_pkg; the final stage is the output register of the core.
module aarm_matrix (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  aarm_pkg::axis_t unit_axis,
	input  aarm_pkg::trig_t trig,
	output logic out_valid,
	output logic signed [31:0] entry [9],
	output logic zero_axis
);
	import aarm_pkg::*;

	localparam int PA [6] = '{0, 1, 2, 0, 0, 1};
	localparam int PB [6] = '{0, 1, 2, 1, 2, 2};

	logic signed [31:0] u [3];
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [63:0] pab_s1 [6];
	logic signed [63:0] pas_s1 [3];
	logic signed [32:0] m_s1, m_s2;
	logic signed [31:0] c_s1, c_s2, c_s3;
	logic z_s1, z_s2, z_s3, z_s4, z_s5;
	logic signed [32:0] tab_s2 [6];
	logic signed [32:0] as_s2 [3];
	logic signed [32:0] as_s3 [3];
	logic signed [63:0] pm_s3 [6];
	logic signed [63:0] e_s4 [9];
	logic signed [63:0] t_c [6];
	logic signed [31:0] ent_s5 [9];

	assign u[0] = unit_axis.x;
	assign u[1] = unit_axis.y;
	assign u[2] = unit_axis.z;

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			t_c[j] = rnd30(pm_s3[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 6; j++) begin
				pab_s1[j] <= 64'(u[PA[j]]) * 64'(u[PB[j]]);
				tab_s2[j] <= 33'(rnd30(pab_s1[j]));
				pm_s3[j] <= 64'(tab_s2[j]) * 64'(m_s2);
			end
			for (int j = 0; j < 3; j++) begin
				pas_s1[j] <= 64'(u[j]) * 64'(trig.s);
				as_s2[j] <= 33'(rnd30(pas_s1[j]));
				as_s3[j] <= as_s2[j];
			end
			m_s1 <= 33'(ONE_Q30) - 33'(trig.c);
			m_s2 <= m_s1;
			c_s1 <= trig.c;
			c_s2 <= c_s1;
			c_s3 <= c_s2;
			z_s1 <= unit_axis.zero;
			z_s2 <= z_s1;
			z_s3 <= z_s2;
			z_s4 <= z_s3;
			z_s5 <= z_s4;
			e_s4[0] <= 64'(c_s3) + t_c[0];
			e_s4[1] <= t_c[3] - 64'(as_s3[2]);
			e_s4[2] <= t_c[4] + 64'(as_s3[1]);
			e_s4[3] <= t_c[3] + 64'(as_s3[2]);
			e_s4[4] <= 64'(c_s3) + t_c[1];
			e_s4[5] <= t_c[5] - 64'(as_s3[0]);
			e_s4[6] <= t_c[4] - 64'(as_s3[1]);
			e_s4[7] <= t_c[5] + 64'(as_s3[0]);
			e_s4[8] <= 64'(c_s3) + t_c[2];
			for (int j = 0; j < 9; j++) begin
				if (z_s4)
					ent_s5[j] <= (j == 0 || j == 4 || j == 8) ? 32'(ONE_Q30) : '0;
				else
					ent_s5[j] <= clamp_q30(e_s4[j]);
			end
		end
	end

	assign out_valid = v_s5;
	assign entry = ent_s5;
	assign zero_axis = z_s5;

endmodule

@@ design/axis_angle_rotation_matrix_core.sv @@
// Top level of the axis-angle (Rodrigues) rotation matrix core.
// Depends on aarm_pkg, aarm_norm, aarm_cordic and aarm_matrix.
//
// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_ready    angle, axis_x, axis_y, axis_z
// out      source     out_valid / out_ready  row0_col0 .. row2_col2, zero_axis
//
// One transfer may be accepted every cycle while the output is not stalled; a transfer passes
// through the square root and division pipeline, then the CORDIC pipeline, then matrix assembly.
// The whole pipeline advances together when the output register is empty or being taken.
// A stall at the output holds every stage, so nothing is lost or repeated.
// Reset clears the valid bits only; data registers are not reset.
module axis_angle_rotation_matrix_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [31:0] angle,
	input  logic signed [31:0] axis_x,
	input  logic signed [31:0] axis_y,
	input  logic signed [31:0] axis_z,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] row0_col0,
	output logic signed [31:0] row0_col1,
	output logic signed [31:0] row0_col2,
	output logic signed [31:0] row1_col0,
	output logic signed [31:0] row1_col1,
	output logic signed [31:0] row1_col2,
	output logic signed [31:0] row2_col0,
	output logic signed [31:0] row2_col1,
	output logic signed [31:0] row2_col2,
	output logic zero_axis
);
	import aarm_pkg::*;

	logic adv;
	logic nv, cv;
	axis_t n_axis, c_axis;
	logic signed [31:0] n_angle;
	trig_t c_trig;
	logic signed [31:0] ent [9];

	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	aarm_norm u_norm (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(in_valid),
		.angle(angle), .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
		.out_valid(nv), .unit_axis(n_axis), .angle_out(n_angle)
	);

	aarm_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(nv),
		.angle(n_angle), .unit_axis(n_axis),
		.out_valid(cv), .axis_out(c_axis), .trig(c_trig)
	);

	aarm_matrix u_matrix (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(cv),
		.unit_axis(c_axis), .trig(c_trig),
		.out_valid(out_valid), .entry(ent), .zero_axis(zero_axis)
	);

	assign row0_col0 = ent[0];
	assign row0_col1 = ent[1];
	assign row0_col2 = ent[2];
	assign row1_col0 = ent[3];
	assign row1_col1 = ent[4];
	assign row1_col2 = ent[5];
	assign row2_col0 = ent[6];
	assign row2_col1 = ent[7];
	assign row2_col2 = ent[8];

	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_axis |-> row0_col0 == 32'sd1073741824 && row1_col1 == 32'sd1073741824
			&& row2_col2 == 32'sd1073741824 && row0_col1 == 32'sd0 && row2_col0 == 32'sd0)
		else $error("zero axis did not give the identity");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> row0_col0 <= 32'sd1073741824 && row0_col0 >= -32'sd1073741824
			&& row1_col2 <= 32'sd1073741824 && row1_col2 >= -32'sd1073741824
			&& row2_col1 <= 32'sd1073741824 && row2_col1 >= -32'sd1073741824)
		else $error("matrix entry outside unit range");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while the output is stalled");

endmodule
